[hw/rtl/owbm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

  localparam int unsigned MaxReadBits = 16;
  localparam int unsigned ShiftW      = (MaxReadBits > 16) ? MaxReadBits : 16;
  localparam int unsigned BitIdxW     = $clog2(MaxReadBits);
  localparam int unsigned ReadValW    = 16;
  localparam int unsigned TimeW       = 10;
  localparam int unsigned SlotW       = 8;
  localparam int unsigned ApbAddrW    = 5;
  localparam int unsigned ApbDataW    = 32;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_RBYTE = 3'd3,
    OP_RWORD = 3'd4
  } opcode_e;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_RLOW  = 5'b00010,
    PH_RWAIT = 5'b00100,
    PH_RTAIL = 5'b01000,
    PH_SLOT  = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PRES = 2'd1,
    ST_STUCK   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    REG_RESET_LOW  = 3'd0,
    REG_PRES_WAIT  = 3'd1,
    REG_RESET_TAIL = 3'd2,
    REG_W1_LOW     = 3'd3,
    REG_W0_LOW     = 3'd4,
    REG_RD_LOW     = 3'd5,
    REG_RD_SAMPLE  = 3'd6,
    REG_SLOT_LEN   = 3'd7
  } reg_idx_e;

  localparam logic [TimeW-1:0] ResetLowRst  = 10'd480;
  localparam logic [TimeW-1:0] PresWaitRst  = 10'd40;
  localparam logic [TimeW-1:0] ResetTailRst = 10'd300;
  localparam logic [SlotW-1:0] W1LowRst     = 8'd5;
  localparam logic [SlotW-1:0] W0LowRst     = 8'd60;
  localparam logic [SlotW-1:0] RdLowRst     = 8'd5;
  localparam logic [SlotW-1:0] RdSampleRst  = 8'd10;
  localparam logic [SlotW-1:0] SlotLenRst   = 8'd61;

endpackage

`default_nettype wire

[hw/rtl/one_wire_bus_master.sv]
`timescale 1ns / 1ps
`default_nettype none

// 1-Wire bus master stepped by one word per microsecond tick. Each accepted input word
// carries the sampled bus level and, while idle, a command (reset with presence check,
// write byte, read byte, read word); it yields exactly one result word with the line
// drive, busy, done, read data and reset status for that tick. One word is taken every
// clock: the state update and the result are one pass of logic from the state registers
// into the result register, so a result is offered the cycle after its word is accepted,
// and input ready falls only while that register holds a result that is not taken.
// Timing registers sit on an APB port at byte address 4*index and should only be
// changed while the master is idle.
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            opcode_i,
  input  wire logic [7:0]            write_data_i,
  input  wire logic                  line_level_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       line_low_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic [ReadValW-1:0]        read_value_o,
  output logic [1:0]                 reset_status_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ApbAddrW-1:0]   paddr,
  input  wire logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]        prdata,
  output logic                       pready
);

  logic [TimeW-1:0] reset_low_q, pres_wait_q, reset_tail_q;
  logic [SlotW-1:0] w1_low_q, w0_low_q, rd_low_q, rd_sample_q, slot_len_q;

  phase_e             ph_q, ph_d;
  opcode_e            kind_q, kind_d;
  logic [TimeW-1:0]   tc_q, tc_d;
  logic [BitIdxW-1:0] idx_q, idx_d;
  logic [ShiftW-1:0]  shift_q, shift_d;

  logic                out_valid_q;
  logic                line_low_q, busy_q, done_q;
  logic [ReadValW-1:0] rval_q;
  logic [1:0]          rstat_q;

  logic                in_acc, cfg_wr;
  reg_idx_e            cfg_idx;

  phase_e              ph_e;
  opcode_e             kind_e;
  logic [TimeW-1:0]    tc_e;
  logic [BitIdxW-1:0]  idx_e, idx_last;
  logic [ShiftW-1:0]   shift_e;
  logic                start;
  logic                drive, busy, done;
  logic [ReadValW-1:0] rval;
  logic [1:0]          rstat;
  logic [TimeW-1:0]    rlow_m1, pwait_m1, rtail_m1;
  logic [SlotW-1:0]    slot_m1, wlt, wlt1, rlt1, samp;
  logic [SlotW:0]      samp_sum;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign cfg_idx    = reg_idx_e'(paddr[ApbAddrW-1:2]);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    unique case (cfg_idx)
      REG_RESET_LOW:  prdata = ApbDataW'(reset_low_q);
      REG_PRES_WAIT:  prdata = ApbDataW'(pres_wait_q);
      REG_RESET_TAIL: prdata = ApbDataW'(reset_tail_q);
      REG_W1_LOW:     prdata = ApbDataW'(w1_low_q);
      REG_W0_LOW:     prdata = ApbDataW'(w0_low_q);
      REG_RD_LOW:     prdata = ApbDataW'(rd_low_q);
      REG_RD_SAMPLE:  prdata = ApbDataW'(rd_sample_q);
      REG_SLOT_LEN:   prdata = ApbDataW'(slot_len_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_low_q  <= ResetLowRst;
      pres_wait_q  <= PresWaitRst;
      reset_tail_q <= ResetTailRst;
      w1_low_q     <= W1LowRst;
      w0_low_q     <= W0LowRst;
      rd_low_q     <= RdLowRst;
      rd_sample_q  <= RdSampleRst;
      slot_len_q   <= SlotLenRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_RESET_LOW:  reset_low_q  <= pwdata[TimeW-1:0];
        REG_PRES_WAIT:  pres_wait_q  <= pwdata[TimeW-1:0];
        REG_RESET_TAIL: reset_tail_q <= pwdata[TimeW-1:0];
        REG_W1_LOW:     w1_low_q     <= pwdata[SlotW-1:0];
        REG_W0_LOW:     w0_low_q     <= pwdata[SlotW-1:0];
        REG_RD_LOW:     rd_low_q     <= pwdata[SlotW-1:0];
        REG_RD_SAMPLE:  rd_sample_q  <= pwdata[SlotW-1:0];
        REG_SLOT_LEN:   slot_len_q   <= pwdata[SlotW-1:0];
        default: ;
      endcase
    end
  end

  // zero-valued times act as one, except in the read sample sum (rd_low + rd_sample)
  assign rlow_m1  = (reset_low_q  == '0) ? '0 : reset_low_q  - TimeW'(1);
  assign pwait_m1 = (pres_wait_q  == '0) ? '0 : pres_wait_q  - TimeW'(1);
  assign rtail_m1 = (reset_tail_q == '0) ? '0 : reset_tail_q - TimeW'(1);
  assign slot_m1  = (slot_len_q   == '0) ? '0 : slot_len_q   - SlotW'(1);
  assign wlt      = shift_e[0] ? w1_low_q : w0_low_q;
  assign wlt1     = (wlt == '0) ? SlotW'(1) : wlt;
  assign rlt1     = (rd_low_q == '0) ? SlotW'(1) : rd_low_q;
  assign samp_sum = {1'b0, rd_low_q} + {1'b0, rd_sample_q};
  assign samp     = (samp_sum > {1'b0, slot_m1}) ? slot_m1 : samp_sum[SlotW-1:0];

  assign start = (ph_q == PH_IDLE) &&
                 (opcode_i == OP_RESET || opcode_i == OP_WRITE ||
                  opcode_i == OP_RBYTE || opcode_i == OP_RWORD);

  always_comb begin
    ph_e    = ph_q;
    kind_e  = kind_q;
    tc_e    = tc_q;
    idx_e   = idx_q;
    shift_e = shift_q;
    if (start) begin
      kind_e  = opcode_e'(opcode_i);
      tc_e    = '0;
      idx_e   = '0;
      shift_e = '0;
      if (opcode_i == OP_RESET) begin
        ph_e = PH_RLOW;
      end else begin
        ph_e = PH_SLOT;
        if (opcode_i == OP_WRITE) begin
          shift_e = ShiftW'(write_data_i);
        end
      end
    end
  end

  assign idx_last = (kind_e == OP_RWORD) ? BitIdxW'(MaxReadBits - 1) : BitIdxW'(7);

  always_comb begin
    ph_d    = ph_e;
    kind_d  = kind_e;
    tc_d    = tc_e;
    idx_d   = idx_e;
    shift_d = shift_e;
    drive   = 1'b0;
    done    = 1'b0;
    rval    = '0;
    rstat   = ST_OK;
    busy    = (ph_e != PH_IDLE);
    unique case (ph_e)
      PH_RLOW: begin
        drive = 1'b1;
        if (tc_e >= rlow_m1) begin
          ph_d = PH_RWAIT;
          tc_d = '0;
        end else begin
          tc_d = tc_e + TimeW'(1);
        end
      end
      PH_RWAIT: begin
        if (tc_e >= pwait_m1) begin
          tc_d = '0;
          if (line_level_i) begin
            done  = 1'b1;
            rstat = ST_NO_PRES;
            ph_d  = PH_IDLE;
          end else begin
            ph_d = PH_RTAIL;
          end
        end else begin
          tc_d = tc_e + TimeW'(1);
        end
      end
      PH_RTAIL: begin
        if (tc_e >= rtail_m1) begin
          tc_d  = '0;
          done  = 1'b1;
          rstat = line_level_i ? ST_OK : ST_STUCK;
          ph_d  = PH_IDLE;
        end else begin
          tc_d = tc_e + TimeW'(1);
        end
      end
      PH_SLOT: begin
        if (kind_e == OP_WRITE) begin
          drive = (tc_e < TimeW'(wlt1));
        end else begin
          drive = (tc_e < TimeW'(rlt1));
          if (tc_e == TimeW'(samp) && line_level_i) begin
            shift_d = shift_e | (ShiftW'(1) << idx_e);
          end
        end
        if (tc_e >= TimeW'(slot_m1)) begin
          tc_d = '0;
          if (kind_e == OP_WRITE) begin
            shift_d = shift_e >> 1;
          end
          if (idx_e == idx_last) begin
            done = 1'b1;
            ph_d = PH_IDLE;
            if (kind_e != OP_WRITE) begin
              rval = shift_d[ReadValW-1:0];
            end
          end else begin
            idx_d = idx_e + BitIdxW'(1);
          end
        end else begin
          tc_d = tc_e + TimeW'(1);
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      kind_q      <= OP_TICK;
      tc_q        <= '0;
      idx_q       <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        ph_q    <= ph_d;
        kind_q  <= kind_d;
        tc_q    <= tc_d;
        idx_q   <= idx_d;
        shift_q <= shift_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_low_q <= drive;
      busy_q     <= busy;
      done_q     <= done;
      rval_q     <= rval;
      rstat_q    <= rstat;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_low_o     = line_low_q;
  assign busy_res_o     = busy_q;
  assign done_res_o     = done_q;
  assign read_value_o   = rval_q;
  assign reset_status_o = rstat_q;

endmodule

`default_nettype wire

[hw/rtl/owbm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module owbm_checker
  import owbm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire logic                line_low_o,
  input wire logic                busy_res_o,
  input wire logic                done_res_o,
  input wire logic [ReadValW-1:0] read_value_o,
  input wire logic [1:0]          reset_status_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o)
    else $error("done word without busy");

  a_drive_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_low_o |-> busy_res_o)
    else $error("line driven while idle");

  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reset_status_o != ST_OK |-> done_res_o && read_value_o == '0)
    else $error("reset status outside a reset done word");

  a_rval_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != '0 |-> done_res_o)
    else $error("read data outside a done word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_low_o) &&
    $stable(busy_res_o) && $stable(done_res_o) && $stable(read_value_o) &&
    $stable(reset_status_o))
    else $error("stalled result word changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .line_low_o     (line_low_o),
  .busy_res_o     (busy_res_o),
  .done_res_o     (done_res_o),
  .read_value_o   (read_value_o),
  .reset_status_o (reset_status_o)
);

`default_nettype wire
